// ===== sv/hds_pkg.sv =====
// Shared types and constants for the 1-D explicit heat diffusion step block.
`timescale 1ns / 1ps
`default_nettype none
package hds_pkg;

    localparam int TEMP_W  = 16;
    localparam int COEF_W  = 16;
    localparam int IDX_W   = 6;
    localparam int DIFF_W  = TEMP_W + 2;
    localparam int PROD_W  = COEF_W + 1 + DIFF_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [COEF_W-1:0]        coef_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam cfg_idx_t CFG_R_COEFF       = 2'd0;
    localparam cfg_idx_t CFG_HOT_TEMP      = 2'd1;
    localparam cfg_idx_t CFG_BOUNDARY_TEMP = 2'd2;

    localparam coef_t R_LIMIT   = 16'h8000;
    localparam coef_t RST_R     = 16'd16384;
    localparam temp_t RST_HOT   = 16'sd11520;
    localparam temp_t RST_BND   = 16'sd9472;
    localparam temp_t TEMP_MAX  = 16'sh7FFF;
    localparam temp_t TEMP_MIN  = 16'sh8000;

    typedef struct packed {
        logic adv;
        logic valid;
        idx_t idx;
        logic hot;
    } sten_ctl_t;

    typedef struct packed {
        logic  valid;
        idx_t  idx;
        temp_t temp;
    } sten_res_t;

endpackage
`default_nettype wire

// ===== sv/hds_cell.sv =====
// One storage cell of the temperature row chain.
`timescale 1ns / 1ps
`default_nettype none
module hds_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          shift_en,
    input  wire logic          load_en,
    input  wire logic          is_hot,
    input  wire hds_pkg::temp_t hot_val,
    input  wire hds_pkg::temp_t shift_in,
    output hds_pkg::temp_t     value
);

    hds_pkg::temp_t cell_reg;
    hds_pkg::temp_t cell_next;

    always_comb begin
        cell_next = cell_reg;
        if (load_en) begin
            cell_next = is_hot ? hot_val : '0;
        end else if (shift_en) begin
            cell_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= is_hot ? hds_pkg::RST_HOT : '0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign value = cell_reg;

endmodule
`default_nettype wire

// ===== sv/hds_stencil.sv =====
// Three-stage stencil pipeline: difference, multiply, floor and saturate; the hot cell is held at hot_val.
`timescale 1ns / 1ps
`default_nettype none
module hds_stencil (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hds_pkg::sten_ctl_t ctl,
    input  wire hds_pkg::temp_t    left,
    input  wire hds_pkg::temp_t    centre,
    input  wire hds_pkg::temp_t    right,
    input  wire hds_pkg::coef_t    r_eff,
    input  wire hds_pkg::temp_t    hot_val,
    output hds_pkg::sten_res_t     res
);

    localparam int TW = hds_pkg::TEMP_W;
    localparam int DW = hds_pkg::DIFF_W;
    localparam int PW = hds_pkg::PROD_W;
    localparam int AW = hds_pkg::ACC_W;
    localparam int FW = hds_pkg::FRAC_W;
    localparam int QW = AW - FW;

    logic                   v1_reg, v2_reg, v3_reg;
    logic                   v1_next, v2_next, v3_next;
    hds_pkg::idx_t          i1_reg, i2_reg, i3_reg;
    logic                   h1_reg, h2_reg;
    hds_pkg::temp_t         c1_reg, c2_reg;
    logic signed [DW-1:0]   d1_reg, d1_next;
    logic signed [PW-1:0]   p2_reg, p2_next;
    hds_pkg::temp_t         t3_reg, t3_next;
    logic signed [AW-1:0]   acc;
    logic signed [QW-1:0]   q;

    always_comb begin
        d1_next = {{2{left[TW-1]}}, left} + {{2{right[TW-1]}}, right}
                - {centre[TW-1], centre, 1'b0};
        p2_next = $signed({1'b0, r_eff}) * d1_reg;
        acc     = {p2_reg[PW-1], p2_reg}
                + {{(AW-TW-FW){c2_reg[TW-1]}}, c2_reg, {FW{1'b0}}};
        q       = acc[AW-1:FW];
        if (h2_reg) begin
            t3_next = hot_val;
        end else if (q > $signed(QW'(hds_pkg::TEMP_MAX))) begin
            t3_next = hds_pkg::TEMP_MAX;
        end else if (q < $signed({{(QW-TW){1'b1}}, hds_pkg::TEMP_MIN})) begin
            t3_next = hds_pkg::TEMP_MIN;
        end else begin
            t3_next = q[TW-1:0];
        end
        v1_next = ctl.adv ? ctl.valid : v1_reg;
        v2_next = ctl.adv ? v1_reg : v2_reg;
        v3_next = ctl.adv ? v2_reg : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            d1_reg <= d1_next;
            c1_reg <= centre;
            i1_reg <= ctl.idx;
            h1_reg <= ctl.hot;
            p2_reg <= p2_next;
            c2_reg <= c1_reg;
            i2_reg <= i1_reg;
            h2_reg <= h1_reg;
            t3_reg <= t3_next;
            i3_reg <= i2_reg;
        end
    end

    assign res.valid = v3_reg;
    assign res.idx   = i3_reg;
    assign res.temp  = t3_reg;

endmodule
`default_nettype wire

// ===== sv/heat_diffusion_1d_explicit_step.sv =====
// Top level: row of temperature cells rotated through the stencil pipeline.
// A step word is accepted; the ring then advances to count CELLS+2, stalled by a held output.
// Results pass three stencil stages and output register; one word per cycle unless stalled.
// Throughput is set by the ring of CELLS cells plus the three pipeline stages.
// A restart word reloads the row and the boundary value and produces no output.
// Reset (aresetn low, synchronous) loads the register defaults and the initial row at once.
`timescale 1ns / 1ps
`default_nettype none
module heat_diffusion_1d_explicit_step #(
    parameter int CELLS = 30
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [5:0] cell_index, [21:6] temperature
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire hds_pkg::cfg_idx_t cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int HOT      = CELLS / 2;
    localparam int LAST_CNT = CELLS + 2;
    localparam int CNT_W    = $clog2(CELLS + 3);

    hds_pkg::temp_t chain [CELLS];

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    hds_pkg::temp_t      prev_reg;
    hds_pkg::temp_t      end_reg, end_next;
    hds_pkg::coef_t      r_reg;
    hds_pkg::temp_t      hot_reg;
    hds_pkg::temp_t      bnd_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    hds_pkg::idx_t       m_idx_reg;
    hds_pkg::temp_t      m_temp_reg;
    logic                m_last_reg;

    logic                accept;
    logic                restart;
    logic                adv;
    logic                finish;
    hds_pkg::coef_t      r_eff;
    hds_pkg::temp_t      left;
    hds_pkg::temp_t      right;
    hds_pkg::sten_ctl_t  ctl;
    hds_pkg::sten_res_t  res;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign restart  = s_tdata[0];
    assign adv      = busy_reg && (!m_tvalid_reg || m_tready);
    assign finish   = adv && (cnt_reg == CNT_W'(LAST_CNT));
    assign r_eff    = (r_reg > hds_pkg::R_LIMIT) ? hds_pkg::R_LIMIT : r_reg;
    assign left     = (cnt_reg == '0) ? end_reg : prev_reg;
    assign right    = (cnt_reg == CNT_W'(CELLS - 1)) ? end_reg : chain[1];

    assign ctl.adv   = adv;
    assign ctl.valid = cnt_reg < CNT_W'(CELLS);
    assign ctl.idx   = hds_pkg::IDX_W'(cnt_reg + CNT_W'(1));
    assign ctl.hot   = cnt_reg == CNT_W'(HOT - 1);

    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            hds_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (adv),
                .load_en  (accept && restart),
                .is_hot   (g == HOT - 1),
                .hot_val  (hot_reg),
                .shift_in ((g == CELLS - 1) ? res.temp : chain[(g + 1) % CELLS]),
                .value    (chain[g])
            );
        end
    endgenerate

    hds_stencil u_stencil (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .left    (left),
        .centre  (chain[0]),
        .right   (right),
        .r_eff   (r_eff),
        .hot_val (hot_reg),
        .res     (res)
    );

    always_comb begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        end_next      = end_reg;
        m_tvalid_next = m_tvalid_reg;
        if (accept && restart) begin
            end_next = bnd_reg;
        end else if (accept) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        if (finish) begin
            busy_next = 1'b0;
            cnt_next  = '0;
            end_next  = bnd_reg;
        end else if (adv) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (adv && res.valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            end_reg      <= hds_pkg::RST_BND;
            m_tvalid_reg <= 1'b0;
            r_reg        <= hds_pkg::RST_R;
            hot_reg      <= hds_pkg::RST_HOT;
            bnd_reg      <= hds_pkg::RST_BND;
        end else begin
            busy_reg     <= busy_next;
            cnt_reg      <= cnt_next;
            end_reg      <= end_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    hds_pkg::CFG_R_COEFF:       r_reg   <= cfg_wdata;
                    hds_pkg::CFG_HOT_TEMP:      hot_reg <= cfg_wdata;
                    hds_pkg::CFG_BOUNDARY_TEMP: bnd_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prev_reg <= chain[0];
        end
        if (adv && res.valid) begin
            m_idx_reg  <= res.idx;
            m_temp_reg <= res.temp;
            m_last_reg <= res.idx == hds_pkg::IDX_W'(CELLS);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_temp_reg, m_idx_reg};
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    a_rise_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(busy_reg))
        else $error("output word without a step in progress");

    a_last_idx : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_last_reg) |-> (m_idx_reg == hds_pkg::IDX_W'(CELLS)))
        else $error("last word carries wrong cell index");

    a_step_start : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !restart) |=> (busy_reg && cnt_reg == '0))
        else $error("step word did not start the ring");

    a_cnt_range : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(LAST_CNT))
        else $error("ring counter out of range");
`endif

endmodule
`default_nettype wire
